### sv/lls_pkg.sv
// shared types, codes and size constants for the ligature longest-match shaper
// no dependencies
package lls_pkg;

    localparam int MAX_RULES_DEF = 64;
    localparam int MAX_SEQ_DEF   = 8;
    localparam int MAX_RUN_DEF   = 256;
    localparam int LIMIT_W       = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic [1:0] {
        REQ_RULE  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_RUN   = 2'd2,
        REQ_NONE  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        KIND_SHAPED   = 2'd0,
        KIND_ACCEPTED = 2'd1,
        KIND_REJECTED = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_LASTCMP,
        ST_DECIDE,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] code_value;
        logic [31:0] rule_glyph;
        logic        last;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_value;
        logic        end_of_run;
        logic [6:0]  rules_loaded;
    } res_t;

    typedef struct packed {
        logic sym_we;
        logic rd_en;
        logic win_we;
        logic shift_en;
    } cell_ctrl_t;

endpackage

### sv/lls_cell.sv
// one window position: window word, its column of rule symbols, compare
// depends on lls_pkg
module lls_cell
    import lls_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF,
    parameter int MAX_SEQ   = MAX_SEQ_DEF,
    parameter int IDX       = 0,
    parameter int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
    parameter int POS_W     = $clog2(MAX_SEQ + 2),
    parameter int LEN_W     = $clog2(MAX_SEQ + 1)
) (
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  sym_waddr,
    input  logic [POS_W-1:0]  sym_pos,
    input  logic [31:0]       sym_wdata,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic [LEN_W-1:0]  win_pos,
    input  logic [31:0]       win_wdata,
    input  logic [31:0]       shift_in,
    output logic [31:0]       win_value,
    output logic              eq
);

    logic [31:0] sym_mem [MAX_RULES];
    logic [31:0] sym_rd_reg;
    logic [31:0] win_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.sym_we && sym_pos == POS_W'(IDX))
        begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        if (ctrl.rd_en)
        begin
            sym_rd_reg <= sym_mem[rd_addr];
        end
    end

    // words move one place toward the head when the head is consumed
    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            win_reg <= shift_in;
        end
        else if (ctrl.win_we && win_pos == LEN_W'(IDX))
        begin
            win_reg <= win_wdata;
        end
    end

    assign win_value = win_reg;
    assign eq        = (win_reg == sym_rd_reg);

endmodule

### sv/ligature_longest_match_shaper.sv
// rule and clear words leave the block idle; a run word that fills the window or ends
// the run keeps it busy for each decision: limit check, R rules scanned one per cycle
// through the cell row, last compare, decide, m window words shifted out one per cycle
// (no scan or last compare with an empty table); the shaped word strobes after decide
// sequential, one word at a time; no word is taken while busy. results are single-cycle strobes, no stall.
// asynchronous active-low reset clears control; tables are unset until written
module ligature_longest_match_shaper
    import lls_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF,
    parameter int MAX_SEQ   = MAX_SEQ_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    output logic               result_valid,
    output res_t               result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam int IDX_W  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int RL_W   = $clog2(MAX_RULES + 1);
    localparam int POS_W  = $clog2(MAX_SEQ + 2);
    localparam int LEN_W  = $clog2(MAX_SEQ + 1);
    localparam int SEEN_W = $clog2(MAX_RUN + 1);

    state_t state_reg, state_next;
    logic [RL_W-1:0]    total_reg, total_next;
    logic [POS_W-1:0]   lp_reg, lp_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic [LIMIT_W-1:0] sent_reg, sent_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic               disc_reg, disc_next;
    logic               final_reg, final_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               rd_pend_reg;
    logic [LEN_W-1:0]   best_reg, best_next;
    logic [31:0]        bglyph_reg, bglyph_next;
    logic [LEN_W-1:0]   shift_cnt_reg, shift_cnt_next;
    logic               rv_reg, rv_next;
    res_t               res_reg, res_next;

    logic [LEN_W-1:0]   len_mem [MAX_RULES];
    logic [31:0]        glyph_mem [MAX_RULES];
    logic [LEN_W-1:0]   len_rd_reg;
    logic [31:0]        glyph_rd_reg;

    cell_ctrl_t         ctrl;
    logic [31:0]        win_val [MAX_SEQ];
    logic [MAX_SEQ-1:0] eq_vec;
    logic [MAX_SEQ-1:0] len_mask;
    logic               match;
    logic               accept;
    logic               room;
    logic               rule_ok;
    logic [LEN_W-1:0]   take;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign room      = (total_reg < RL_W'(MAX_RULES));
    assign rule_ok   = room && (lp_reg < POS_W'(MAX_SEQ));

    // cell row
    genvar g;
    generate
        for (g = 0; g < MAX_SEQ; g++)
        begin : g_cell
            logic [31:0] nb;
            if (g == MAX_SEQ - 1)
            begin : g_end
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = win_val[g+1];
            end
            lls_cell #(
                .MAX_RULES (MAX_RULES),
                .MAX_SEQ   (MAX_SEQ),
                .IDX       (g)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .sym_waddr (total_reg[IDX_W-1:0]),
                .sym_pos   (lp_reg),
                .sym_wdata (req.code_value),
                .rd_addr   (scan_idx_reg),
                .win_pos   (fill_reg),
                .win_wdata (req.code_value),
                .shift_in  (nb),
                .win_value (win_val[g]),
                .eq        (eq_vec[g])
            );
            assign len_mask[g] = (LEN_W'(g) < len_rd_reg);
        end
    endgenerate

    assign match = &(eq_vec | ~len_mask);
    assign take  = (best_reg != '0) ? best_reg : LEN_W'(1);

    always_comb
    begin
        ctrl.sym_we   = accept && req.req_type == REQ_RULE && rule_ok;
        ctrl.rd_en    = (state_reg == ST_SCAN);
        ctrl.win_we   = accept && req.req_type == REQ_RUN && !disc_reg
                        && seen_reg < SEEN_W'(MAX_RUN);
        ctrl.shift_en = (state_reg == ST_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_RULE && req.last && rule_ok)
        begin
            len_mem[total_reg[IDX_W-1:0]]   <= LEN_W'(lp_reg + 1'b1);
            glyph_mem[total_reg[IDX_W-1:0]] <= req.rule_glyph;
        end
        if (ctrl.rd_en)
        begin
            len_rd_reg   <= len_mem[scan_idx_reg];
            glyph_rd_reg <= glyph_mem[scan_idx_reg];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.req_type == REQ_RUN && ctrl.win_we
                    && (req.last || fill_reg + 1'b1 >= LEN_W'(MAX_SEQ)))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sent_reg >= limit_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (total_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (RL_W'(scan_idx_reg) + 1'b1 >= total_reg)
                begin
                    state_next = ST_LASTCMP;
                end
            end
            ST_LASTCMP:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (shift_cnt_reg == LEN_W'(1))
                begin
                    state_next = (final_reg && fill_reg != '0) ? ST_CHECK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        total_next     = total_reg;
        lp_next        = lp_reg;
        fill_next      = fill_reg;
        seen_next      = seen_reg;
        sent_next      = sent_reg;
        disc_next      = disc_reg;
        final_next     = final_reg;
        scan_idx_next  = scan_idx_reg;
        best_next      = best_reg;
        bglyph_next    = bglyph_reg;
        shift_cnt_next = shift_cnt_reg;
        rv_next        = 1'b0;
        res_next       = res_reg;

        if (rd_pend_reg && len_rd_reg > best_reg && len_rd_reg <= fill_reg && match)
        begin
            best_next   = len_rd_reg;
            bglyph_next = glyph_rd_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_RULE:
                        begin
                            if (lp_reg <= POS_W'(MAX_SEQ))
                            begin
                                lp_next = lp_reg + 1'b1;
                            end
                            if (req.last)
                            begin
                                lp_next = '0;
                                rv_next = 1'b1;
                                res_next.out_value  = '0;
                                res_next.end_of_run = 1'b1;
                                if (rule_ok)
                                begin
                                    total_next = total_reg + 1'b1;
                                    res_next.kind = KIND_ACCEPTED;
                                end
                                else
                                begin
                                    res_next.kind = KIND_REJECTED;
                                end
                                res_next.rules_loaded = 7'(total_next);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            total_next = '0;
                            lp_next    = '0;
                        end
                        REQ_RUN:
                        begin
                            if (disc_reg)
                            begin
                                if (req.last)
                                begin
                                    disc_next = 1'b0;
                                    fill_next = '0;
                                    seen_next = '0;
                                    sent_next = '0;
                                end
                            end
                            else if (!ctrl.win_we)
                            begin
                                rv_next = 1'b1;
                                res_next.kind         = KIND_ERROR;
                                res_next.out_value    = '0;
                                res_next.end_of_run   = 1'b1;
                                res_next.rules_loaded = 7'(total_reg);
                                if (req.last)
                                begin
                                    fill_next = '0;
                                    seen_next = '0;
                                    sent_next = '0;
                                end
                                else
                                begin
                                    disc_next = 1'b1;
                                end
                            end
                            else
                            begin
                                seen_next  = seen_reg + 1'b1;
                                fill_next  = fill_reg + 1'b1;
                                final_next = req.last;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                best_next     = '0;
                scan_idx_next = '0;
                if (sent_reg >= limit_reg)
                begin
                    rv_next = 1'b1;
                    res_next.kind         = KIND_ERROR;
                    res_next.out_value    = '0;
                    res_next.end_of_run   = 1'b1;
                    res_next.rules_loaded = 7'(total_reg);
                    if (final_reg)
                    begin
                        fill_next = '0;
                        seen_next = '0;
                        sent_next = '0;
                    end
                    else
                    begin
                        disc_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            ST_LASTCMP:
            begin
            end
            ST_DECIDE:
            begin
                fill_next      = fill_reg - take;
                shift_cnt_next = take;
                sent_next      = sent_reg + 1'b1;
                rv_next        = 1'b1;
                res_next.kind         = KIND_SHAPED;
                res_next.out_value    = (best_reg != '0) ? bglyph_reg : win_val[0];
                res_next.end_of_run   = final_reg && (fill_next == '0);
                res_next.rules_loaded = 7'(total_reg);
            end
            ST_SHIFT:
            begin
                shift_cnt_next = shift_cnt_reg - 1'b1;
                if (shift_cnt_reg == LEN_W'(1) && final_reg && fill_reg == '0)
                begin
                    seen_next = '0;
                    sent_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            lp_reg        <= '0;
            fill_reg      <= '0;
            seen_reg      <= '0;
            sent_reg      <= '0;
            disc_reg      <= 1'b0;
            final_reg     <= 1'b0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            shift_cnt_reg <= '0;
            rv_reg        <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            lp_reg        <= lp_next;
            fill_reg      <= fill_next;
            seen_reg      <= seen_next;
            sent_reg      <= sent_next;
            disc_reg      <= disc_next;
            final_reg     <= final_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= (state_reg == ST_SCAN);
            shift_cnt_reg <= shift_cnt_next;
            rv_reg        <= rv_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        bglyph_reg <= bglyph_next;
        res_reg    <= res_next;
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

### sv/lls_checker.sv
// port-level checks on the shaper's result words
// depends on lls_pkg; bound to ligature_longest_match_shaper
module lls_checker
    import lls_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input res_t result
);

    // status and error words always close their group
    a_status_eor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_SHAPED |-> result.end_of_run)
        else $error("status word without end_of_run");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_SHAPED |-> result.out_value == '0)
        else $error("status word with nonzero value");

    a_rule_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.rules_loaded <= 7'(MAX_RULES))
        else $error("rule count above table size");

    // a word only follows an accepted request or work in progress
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy) || $past(busy))
        else $error("result word with no cause");

endmodule

bind ligature_longest_match_shaper lls_checker #(
    .MAX_RULES (MAX_RULES)
) u_lls_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### dv/ligature_longest_match_shaper_tb.sv
// testbench for the ligature longest-match shaper: directed and random words
// depends on lls_pkg and ligature_longest_match_shaper
module ligature_longest_match_shaper_tb
    import lls_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // scoreboard: a copy of the shaper state producing expected result words
    class shaper_board;
        logic [31:0] syms [MAX_RULES_DEF*MAX_SEQ_DEF];
        int unsigned lens [MAX_RULES_DEF];
        logic [31:0] glyphs [MAX_RULES_DEF];
        int unsigned total, load_pos, fill, seen, sent;
        logic [31:0] win [MAX_SEQ_DEF];
        bit discarding;
        int unsigned limit;
        res_t pending [$];
        int errors;
        int checked;

        function new();
            total = 0; load_pos = 0; limit = LIMIT_RESET;
            errors = 0; checked = 0;
            clear_run();
        endfunction

        function void clear_run();
            fill = 0; seen = 0; sent = 0; discarding = 1'b0;
        endfunction

        function void push(kind_t k, logic [31:0] v, bit eor);
            res_t r;
            r.kind = k;
            r.out_value = v;
            r.end_of_run = eor;
            r.rules_loaded = total[6:0];
            pending.push_back(r);
        endfunction

        function bit shape_head(bit fin);
            int unsigned best, m;
            logic [31:0] g;
            bit hit;
            best = 0; g = '0;
            if (sent >= limit) return 1'b0;
            for (int i = 0; i < total; i++) begin
                if (lens[i] <= best || lens[i] > fill) continue;
                hit = 1'b1;
                for (int j = 0; j < lens[i]; j++)
                    if (win[j] != syms[i*MAX_SEQ_DEF+j]) hit = 1'b0;
                if (hit) begin
                    best = lens[i];
                    g = glyphs[i];
                end
            end
            if (best > 0) m = best;
            else begin
                m = 1;
                g = win[0];
            end
            for (int j = 0; j + m < fill; j++) win[j] = win[j+m];
            fill -= m;
            sent++;
            push(KIND_SHAPED, g, fin && fill == 0);
            return 1'b1;
        endfunction

        function void note_word(req_t q);
            bit room, ok;
            if (q.req_type == REQ_RULE) begin
                room = total < MAX_RULES_DEF;
                if (room && load_pos < MAX_SEQ_DEF) syms[total*MAX_SEQ_DEF+load_pos] = q.code_value;
                if (load_pos <= MAX_SEQ_DEF) load_pos++;
                if (!q.last) return;
                if (room && load_pos <= MAX_SEQ_DEF) begin
                    lens[total] = load_pos;
                    glyphs[total] = q.rule_glyph;
                    total++;
                    push(KIND_ACCEPTED, '0, 1'b1);
                end else push(KIND_REJECTED, '0, 1'b1);
                load_pos = 0;
                return;
            end
            if (q.req_type == REQ_CLEAR) begin
                total = 0; load_pos = 0;
                return;
            end
            if (q.req_type != REQ_RUN) return;
            if (discarding) begin
                if (q.last) clear_run();
                return;
            end
            ok = 1'b1;
            if (seen >= MAX_RUN_DEF) ok = 1'b0;
            else begin
                seen++;
                if (fill < MAX_SEQ_DEF) begin
                    win[fill] = q.code_value;
                    fill++;
                end
                if (!q.last) begin
                    if (fill >= MAX_SEQ_DEF && !shape_head(1'b0)) ok = 1'b0;
                end else begin
                    while (ok && fill > 0)
                        if (!shape_head(1'b1)) ok = 1'b0;
                    if (ok) clear_run();
                end
            end
            if (!ok) begin
                push(KIND_ERROR, '0, 1'b1);
                if (q.last) clear_run();
                else discarding = 1'b1;
            end
        endfunction

        function void check_word(res_t r);
            res_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word kind=%0d value=%h", r.kind, r.out_value);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (r.kind !== e.kind) begin
                $error("kind: expected %0d actual %0d", e.kind, r.kind); errors++;
            end
            if (r.out_value !== e.out_value) begin
                $error("out_value: expected %h actual %h", e.out_value, r.out_value); errors++;
            end
            if (r.end_of_run !== e.end_of_run) begin
                $error("end_of_run: expected %0d actual %0d", e.end_of_run, r.end_of_run);
                errors++;
            end
            if (r.rules_loaded !== e.rules_loaded) begin
                $error("rules_loaded: expected %0d actual %0d", e.rules_loaded, r.rules_loaded);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy, result_valid, cfg_valid, cfg_ready;
    req_t req;
    res_t result;
    logic [LIMIT_W-1:0] cfg_data;
    shaper_board board;
    int words_sent;
    logic [31:0] alphabet [4];

    ligature_longest_match_shaper u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && result_valid) board.check_word(result);

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 2);
        repeat (n) @(posedge clk);
    endtask

    // start stays high between back-to-back words; a gap or a drain drops it
    task automatic send_word(req_code_t t, logic [31:0] code, logic [31:0] g, bit lst);
        req_t q;
        q.req_type = t;
        q.code_value = code;
        q.rule_glyph = g;
        q.last = lst;
        start <= 1'b1;
        req <= q;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_word(q);
        words_sent++;
        if ($urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            @(posedge clk);
            idle_gap();
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while ((board.pending.size() != 0 || busy) && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (700) @(posedge clk);
    endtask

    task automatic write_limit(int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[LIMIT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.limit = v;
        @(posedge clk);
    endtask

    task automatic send_rule(int len, logic [31:0] g);
        for (int i = 0; i < len; i++)
            send_word(REQ_RULE, alphabet[$urandom_range(0, 3)], g, i == len - 1);
    endtask

    task automatic send_run(int len, bit wide);
        logic [31:0] c;
        for (int i = 0; i < len; i++) begin
            c = wide ? $urandom : alphabet[$urandom_range(0, 3)];
            send_word(REQ_RUN, c, $urandom, i == len - 1);
        end
    endtask

    initial begin
        board = new();
        words_sent = 0;
        alphabet[0] = 32'h0000_0000; alphabet[1] = 32'hFFFF_FFFF;
        alphabet[2] = 32'h0000_0041; alphabet[3] = 32'h8000_0066;
        rst_n = 0; start = 0; cfg_valid = 0; cfg_data = '0; req = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rules of length 1, 2 and max, an overlong rule, ignored and clear
        send_word(REQ_RULE, 32'h41, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_RULE, 32'h41, 32'h0, 1'b0);
        send_word(REQ_RULE, 32'h41, 32'h1234_5678, 1'b1);
        send_rule(8, 32'hAAAA_5555);
        send_rule(9, 32'h5555_AAAA);
        send_word(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_run(3, 1'b0);
        send_word(REQ_RUN, 32'h41, 32'h0, 1'b0);
        send_word(REQ_CLEAR, 32'h0, 32'h0, 1'b0);
        send_word(REQ_RUN, 32'h41, 32'h0, 1'b1);
        send_run(1, 1'b1);
        write_limit(0);
        send_run(2, 1'b0);
        write_limit(1);
        send_run(3, 1'b0);

        // fill the table to test table-full rejection
        write_limit(256);
        for (int i = 0; i < 66; i++) send_word(REQ_RULE, alphabet[i % 4], i, 1'b1);
        send_run(10, 1'b0);
        send_word(REQ_CLEAR, 32'h0, 32'h0, 1'b0);

        // random: small tables and runs, mostly over a small alphabet
        for (int ph = 0; ph < 2; ph++) begin
            write_limit(ph == 0 ? 511 : 5);
            for (int k = 0; k < 5; k++) begin
                case ($urandom_range(0, 9))
                    0: send_word(REQ_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)));
                    1: send_word(REQ_NONE, $urandom, $urandom, 1'($urandom_range(0, 1)));
                    2, 3, 4: send_rule($urandom_range(1, 9), $urandom);
                    default: send_run($urandom_range(1, 12), $urandom_range(0, 4) == 0);
                endcase
            end
        end

        drain();
        $display("run covered %0d input words and %0d result words over several limits",
                 words_sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### filelist.f
sv/lls_pkg.sv
sv/lls_cell.sv
sv/ligature_longest_match_shaper.sv
sv/lls_checker.sv
dv/ligature_longest_match_shaper_tb.sv
